>>> design/snfr_pkg.sv
// Shared types, codes and helpers for the switch neighbor flow-rule block.
// No dependencies; imported by every module of the block.
package snfr_pkg;

  localparam int ADDR_WIDTH = 16;
  localparam int ID_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_RULE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ACT_DROP    = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_DELIVER = 2'd2;

  localparam logic [1:0] PORT_NONE  = 2'd0;
  localparam logic [1:0] PORT_LEFT  = 2'd1;
  localparam logic [1:0] PORT_RIGHT = 2'd2;
  localparam logic [1:0] PORT_LOCAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SWITCHES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IP       = 1'd1;

  typedef struct packed {
    logic                  opcode;
    logic [ID_W-1:0]       switch_id;
    logic [ID_W-1:0]       left_id;
    logic [ID_W-1:0]       right_id;
    logic [ADDR_WIDTH-1:0] range_low;
    logic [ADDR_WIDTH-1:0] range_high;
    logic [ADDR_WIDTH-1:0] src_addr;
    logic [ADDR_WIDTH-1:0] dst_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            result_kind;
    logic [1:0]            action;
    logic [1:0]            out_port;
    logic [ADDR_WIDTH-1:0] match_low;
    logic [ADDR_WIDTH-1:0] match_high;
  } out_item_t;

  // Table entry body; the valid mark lives in flops beside the memory.
  typedef struct packed {
    logic [ID_W-1:0]       left;
    logic [ID_W-1:0]       right;
    logic [ADDR_WIDTH-1:0] low;
    logic [ADDR_WIDTH-1:0] high;
  } entry_t;

  // Table access from the sequencer; slots are table index (id - 1).
  typedef struct packed {
    logic            wr_en;
    logic [ID_W-1:0] wr_slot;
    entry_t          wr_entry;
    logic [ID_W-1:0] rd_slot_a;
    logic [ID_W-1:0] rd_slot_b;
  } tbl_req_t;

  function automatic logic owns(entry_t e, logic [ADDR_WIDTH-1:0] addr);
    return (addr >= e.low) && (addr <= e.high);
  endfunction

endpackage

>>> design/snfr_table.sv
// Switch table: one write port, two registered read ports, valid flops.
// Depends on snfr_pkg.
module snfr_table import snfr_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tbl_req_t               req,
  output entry_t                 rd_a,
  output entry_t                 rd_b,
  output logic [TABLE_DEPTH-1:0] valid
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_a_r, rd_b_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_slot[IDX_W-1:0]] <= req.wr_entry;
    end
    rd_a_r <= mem[req.rd_slot_a[IDX_W-1:0]];
    rd_b_r <= mem[req.rd_slot_b[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_slot[IDX_W-1:0]] <= 1'b1;
    end
  end

  assign rd_a  = rd_a_r;
  assign rd_b  = rd_b_r;
  assign valid = valid_r;

endmodule

>>> design/snfr_ctrl.sv
// Request sequencer: open writes, query lookups over the table, output register.
// Depends on snfr_pkg; drives snfr_table through a tbl_req_t.
module snfr_ctrl import snfr_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic [ID_W-1:0]        num_switches,
  input  logic [ADDR_WIDTH-1:0]  max_ip,
  output tbl_req_t               tbl_req,
  input  entry_t                 rd_a,
  input  entry_t                 rd_b,
  input  logic [TABLE_DEPTH-1:0] valid
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [ID_W-1:0] DEPTH_ID = ID_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SELF = 2'd1;
  localparam logic [1:0] ST_NB   = 2'd2;
  localparam logic [1:0] ST_PUT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [ADDR_WIDTH-1:0] dst_r, dst_nxt;
  logic                  self_ok_r, self_ok_nxt;
  logic                  src_ok_r, src_ok_nxt;
  logic                  left_ok_r, left_ok_nxt;
  logic                  right_ok_r, right_ok_nxt;
  out_item_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic accept;
  logic out_free;

  // An id names a live slot when nonzero, within the table and opened.
  function automatic logic id_live(logic [ID_W-1:0] id, logic [TABLE_DEPTH-1:0] v);
    logic [ID_W-1:0] slot;
    slot = id - 1'b1;
    return (id != '0) && (id <= DEPTH_ID) && v[slot[IDX_W-1:0]];
  endfunction

  function automatic out_item_t rule(logic [1:0] act, logic [1:0] port,
                                     logic [ADDR_WIDTH-1:0] lo,
                                     logic [ADDR_WIDTH-1:0] hi);
    out_item_t r;
    r.result_kind = KIND_RULE;
    r.action      = act;
    r.out_port    = port;
    r.match_low   = lo;
    r.match_high  = hi;
    return r;
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    logic open_err;
    state_nxt     = state_r;
    dst_nxt       = dst_r;
    self_ok_nxt   = self_ok_r;
    src_ok_nxt    = src_ok_r;
    left_ok_nxt   = left_ok_r;
    right_ok_nxt  = right_ok_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    tbl_req                   = '0;
    tbl_req.wr_slot           = in_data.switch_id - 1'b1;
    tbl_req.wr_entry.left     = in_data.left_id;
    tbl_req.wr_entry.right    = in_data.right_id;
    tbl_req.wr_entry.low      = in_data.range_low;
    tbl_req.wr_entry.high     = in_data.range_high;
    tbl_req.rd_slot_a         = in_data.switch_id - 1'b1;

    open_err = (in_data.switch_id > num_switches) || (in_data.left_id > num_switches) ||
               (in_data.right_id > num_switches) || (in_data.switch_id > DEPTH_ID) ||
               (in_data.left_id > DEPTH_ID) || (in_data.right_id > DEPTH_ID);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_OPEN) begin
            res_nxt = '0;
            if (open_err) begin
              res_nxt.result_kind = KIND_ERROR;
            end else begin
              res_nxt.result_kind = KIND_ACK;
              tbl_req.wr_en       = (in_data.switch_id != '0);
            end
            state_nxt = ST_PUT;
          end else begin
            dst_nxt     = in_data.dst_addr;
            self_ok_nxt = id_live(in_data.switch_id, valid);
            src_ok_nxt  = (in_data.src_addr <= max_ip);
            state_nxt   = ST_SELF;
          end
        end
      end
      ST_SELF: begin
        // own entry is on read port A now
        tbl_req.rd_slot_a = rd_a.left - 1'b1;
        tbl_req.rd_slot_b = rd_a.right - 1'b1;
        left_ok_nxt       = id_live(rd_a.left, valid);
        right_ok_nxt      = id_live(rd_a.right, valid);
        if (!self_ok_r || !src_ok_r) begin
          res_nxt   = rule(ACT_DROP, PORT_NONE, dst_r, dst_r);
          state_nxt = ST_PUT;
        end else if (owns(rd_a, dst_r)) begin
          res_nxt   = rule(ACT_DELIVER, PORT_LOCAL, dst_r, dst_r);
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        priority if (left_ok_r && owns(rd_a, dst_r)) begin
          res_nxt = rule(ACT_FORWARD, PORT_LEFT, rd_a.low, rd_a.high);
        end else if (right_ok_r && owns(rd_b, dst_r)) begin
          res_nxt = rule(ACT_FORWARD, PORT_RIGHT, rd_b.low, rd_b.high);
        end else begin
          res_nxt = rule(ACT_DROP, PORT_NONE, dst_r, dst_r);
        end
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r      <= dst_nxt;
    self_ok_r  <= self_ok_nxt;
    src_ok_r   <= src_ok_nxt;
    left_ok_r  <= left_ok_nxt;
    right_ok_r <= right_ok_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/switch_neighbor_flow_rule.sv
// Top level of the switch neighbor flow-rule block: config registers and wiring.
// Depends on snfr_pkg, snfr_table and snfr_ctrl.

// Keeps a table of up to TABLE_DEPTH switches (id n lives in slot n-1, id 0 is
// "none"). An open beat registers a switch with its neighbors and owned
// destination range and answers ack, or error when an id is above
// num_switches or the table depth. A query beat answers one rule: drop,
// deliver on port 3, or forward on port 1/2 toward the neighbor that owns the
// destination. Timing: one beat is in flight at a time. An open goes from
// acceptance through the table write to the move into the output register,
// which waits while the output register is full and stalled. A query reads
// its own entry and, when that does not settle it, then both neighbor
// entries, all through the registered read ports of the table memory.
// The output register lets the next beat be taken while the previous
// result waits on out_stall. Valid marks sit in flops cleared by reset, so
// no clearing pass is needed. Config writes (cfg_index 0 num_switches,
// 1 max_ip) are expected only while the block is idle.
module switch_neighbor_flow_rule import snfr_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ID_W-1:0]        num_switches_r;
  logic [ADDR_WIDTH-1:0]  max_ip_r;

  tbl_req_t               tbl_req;
  entry_t                 rd_a, rd_b;
  logic [TABLE_DEPTH-1:0] valid;

  // Config registers; reset values 8 and 1000.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_switches_r <= ID_W'(8);
      max_ip_r       <= ADDR_WIDTH'(1000);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NUM_SWITCHES: num_switches_r <= cfg_data[ID_W-1:0];
        CFG_MAX_IP:       max_ip_r       <= cfg_data[ADDR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  snfr_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rd_a  (rd_a),
    .rd_b  (rd_b),
    .valid (valid)
  );

  snfr_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .num_switches (num_switches_r),
    .max_ip       (max_ip_r),
    .tbl_req      (tbl_req),
    .rd_a         (rd_a),
    .rd_b         (rd_b),
    .valid        (valid)
  );

endmodule

>>> tb/tb_switch_neighbor_flow_rule.sv
// Testbench for switch_neighbor_flow_rule: directed and random open/query beats
// checked against an in-bench flow-rule predictor. Depends on snfr_pkg and the DUT.
`timescale 1ns / 100ps

module tb_switch_neighbor_flow_rule;
  import snfr_pkg::*;

  localparam int TABLE_DEPTH    = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off to back the block up
  localparam int SETTLE_CYCLES  = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  switch_neighbor_flow_rule #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Requests waiting for the driver, and answers the block still owes us.
  in_item_t  pending_requests[$];
  out_item_t expected_answers[$];

  int error_count  = 0;
  int answers_seen = 0;
  int quiet_cycles = 0;
  bit steady_flow  = 1'b0;   // set for the phase that runs with no idling at all

  // Mirror of the switch table and the two config registers, indexed by switch id.
  logic                  sw_valid [1:TABLE_DEPTH];
  logic [ID_W-1:0]       sw_left  [1:TABLE_DEPTH];
  logic [ID_W-1:0]       sw_right [1:TABLE_DEPTH];
  logic [ADDR_WIDTH-1:0] sw_low   [1:TABLE_DEPTH];
  logic [ADDR_WIDTH-1:0] sw_high  [1:TABLE_DEPTH];
  logic [3:0]            cfg_switch_limit = 4'd8;
  logic [ADDR_WIDTH-1:0] cfg_src_limit    = 16'd1000;

  // Ranges handed out by the generator, so queries can aim at owned addresses.
  int plan_low  [1:TABLE_DEPTH];
  int plan_high [1:TABLE_DEPTH];
  bit plan_set  [1:TABLE_DEPTH];

  initial begin
    for (int i = 1; i <= TABLE_DEPTH; i++) begin
      sw_valid[i] = 1'b0;
      sw_left[i]  = '0;
      sw_right[i] = '0;
      sw_low[i]   = '0;
      sw_high[i]  = '0;
      plan_set[i] = 1'b0;
      plan_low[i] = 0;
      plan_high[i] = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Id 0 and ids past the table never resolve; otherwise the valid mark decides.
  function automatic bit switch_known(logic [ID_W-1:0] id);
    if (id == 0 || id > TABLE_DEPTH) return 1'b0;
    return sw_valid[id];
  endfunction

  // Empty ranges (low above high) fall out naturally: no address passes both tests.
  function automatic bit switch_owns(logic [ID_W-1:0] id, logic [ADDR_WIDTH-1:0] addr);
    return (addr >= sw_low[id]) && (addr <= sw_high[id]);
  endfunction

  // Computes the answer to one accepted request and applies any table write.
  function automatic out_item_t predict_flow_answer(in_item_t rq);
    out_item_t        ans;
    logic [ID_W-1:0]  nb;
    ans = '0;
    if (rq.opcode == OP_OPEN) begin
      if (rq.switch_id > cfg_switch_limit || rq.left_id > cfg_switch_limit ||
          rq.right_id > cfg_switch_limit || rq.switch_id > TABLE_DEPTH ||
          rq.left_id > TABLE_DEPTH || rq.right_id > TABLE_DEPTH) begin
        ans.result_kind = KIND_ERROR;
      end else begin
        ans.result_kind = KIND_ACK;
        // id 0 is acked but has no slot to write
        if (rq.switch_id != 0) begin
          sw_valid[rq.switch_id] = 1'b1;
          sw_left[rq.switch_id]  = rq.left_id;
          sw_right[rq.switch_id] = rq.right_id;
          sw_low[rq.switch_id]   = rq.range_low;
          sw_high[rq.switch_id]  = rq.range_high;
        end
      end
      return ans;
    end

    // Query: default is a drop rule pinned to the destination.
    ans.result_kind = KIND_RULE;
    ans.action      = ACT_DROP;
    ans.out_port    = PORT_NONE;
    ans.match_low   = rq.dst_addr;
    ans.match_high  = rq.dst_addr;
    if (!switch_known(rq.switch_id) || rq.src_addr > cfg_src_limit) return ans;

    if (switch_owns(rq.switch_id, rq.dst_addr)) begin
      ans.action   = ACT_DELIVER;
      ans.out_port = PORT_LOCAL;
      return ans;
    end

    // Left neighbor has priority over right when both would match.
    nb = sw_left[rq.switch_id];
    if (switch_known(nb) && switch_owns(nb, rq.dst_addr)) begin
      ans.action     = ACT_FORWARD;
      ans.out_port   = PORT_LEFT;
      ans.match_low  = sw_low[nb];
      ans.match_high = sw_high[nb];
      return ans;
    end
    nb = sw_right[rq.switch_id];
    if (switch_known(nb) && switch_owns(nb, rq.dst_addr)) begin
      ans.action     = ACT_FORWARD;
      ans.out_port   = PORT_RIGHT;
      ans.match_low  = sw_low[nb];
      ans.match_high = sw_high[nb];
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Every field starts random so that fields the opcode ignores still toggle.
  function automatic in_item_t random_fields();
    in_item_t rq;
    rq.opcode     = 1'($urandom_range(1));
    rq.switch_id  = ID_W'($urandom_range(15));
    rq.left_id    = ID_W'($urandom_range(15));
    rq.right_id   = ID_W'($urandom_range(15));
    rq.range_low  = ADDR_WIDTH'($urandom_range(16'hFFFF));
    rq.range_high = ADDR_WIDTH'($urandom_range(16'hFFFF));
    rq.src_addr   = ADDR_WIDTH'($urandom_range(16'hFFFF));
    rq.dst_addr   = ADDR_WIDTH'($urandom_range(16'hFFFF));
    return rq;
  endfunction

  function automatic void queue_open(int id, int lid, int rid, int lo, int hi);
    in_item_t rq;
    rq = random_fields();
    rq.opcode     = OP_OPEN;
    rq.switch_id  = ID_W'(id);
    rq.left_id    = ID_W'(lid);
    rq.right_id   = ID_W'(rid);
    rq.range_low  = ADDR_WIDTH'(lo);
    rq.range_high = ADDR_WIDTH'(hi);
    pending_requests.push_back(rq);
  endfunction

  function automatic void queue_query(int id, int src, int dst);
    in_item_t rq;
    rq = random_fields();
    rq.opcode    = OP_QUERY;
    rq.switch_id = ID_W'(id);
    rq.src_addr  = ADDR_WIDTH'(src);
    rq.dst_addr  = ADDR_WIDTH'(dst);
    pending_requests.push_back(rq);
  endfunction

  // Mostly well-formed traffic: opens build a chain of neighbors with sane
  // ranges, queries come from legal sources and aim at owned ranges and their
  // edges. The rest is noise: wild ids, empty ranges, random addresses.
  function automatic in_item_t draw_switch_request();
    in_item_t rq;
    int       top;
    int       s;
    rq  = random_fields();
    top = (cfg_switch_limit < TABLE_DEPTH) ? cfg_switch_limit : TABLE_DEPTH;
    rq.opcode = ($urandom_range(99) < 40) ? OP_OPEN : OP_QUERY;
    if (top >= 1 && $urandom_range(99) < 85) rq.switch_id = ID_W'($urandom_range(1, top));

    if (rq.opcode == OP_OPEN) begin
      if ($urandom_range(99) < 85) begin
        rq.left_id  = ID_W'((rq.switch_id > 1 && $urandom_range(3) != 0) ?
                            rq.switch_id - 1 : $urandom_range(0, top));
        rq.right_id = ID_W'((rq.switch_id < top && $urandom_range(3) != 0) ?
                            rq.switch_id + 1 : $urandom_range(0, top));
      end
      case ($urandom_range(9))
        8: begin
          // empty range
          rq.range_low  = ADDR_WIDTH'($urandom_range(1, 16'hFFFF));
          rq.range_high = ADDR_WIDTH'($urandom_range(0, rq.range_low - 1));
        end
        9: ;  // keep fully random bounds
        default: begin
          rq.range_low  = ADDR_WIDTH'($urandom_range(0, 60000));
          rq.range_high = ADDR_WIDTH'(rq.range_low + $urandom_range(0, 5000));
        end
      endcase
      if (rq.switch_id >= 1 && rq.switch_id <= TABLE_DEPTH) begin
        plan_set[rq.switch_id]  = 1'b1;
        plan_low[rq.switch_id]  = rq.range_low;
        plan_high[rq.switch_id] = rq.range_high;
      end
    end else begin
      if ($urandom_range(99) < 85) rq.src_addr = ADDR_WIDTH'($urandom_range(0, cfg_src_limit));
      s = $urandom_range(1, TABLE_DEPTH);
      if ($urandom_range(99) < 75 && plan_set[s] && plan_low[s] <= plan_high[s]) begin
        case ($urandom_range(4))
          0: rq.dst_addr = ADDR_WIDTH'(plan_low[s]);
          1: rq.dst_addr = ADDR_WIDTH'(plan_high[s]);
          2: rq.dst_addr = ADDR_WIDTH'($urandom_range(plan_low[s], plan_high[s]));
          3: rq.dst_addr = ADDR_WIDTH'(plan_low[s] - 1);
          default: rq.dst_addr = ADDR_WIDTH'(plan_high[s] + 1);
        endcase
      end
    end
    return rq;
  endfunction

  // Both registers are written back to back while the block is idle.
  task automatic set_rules_config(int switches, int src_limit);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_NUM_SWITCHES;
    cfg_data  <= CFG_DATA_W'(switches);
    @(posedge clk);
    cfg_index <= CFG_MAX_IP;
    cfg_data  <= CFG_DATA_W'(src_limit);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_switch_limit = 4'(switches);
    cfg_src_limit    = ADDR_WIDTH'(src_limit);
  endtask

  // Sampled on the falling edge so the driver and monitor have settled.
  task automatic wait_until_drained(int extra);
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: directed beats at reset settings, then random phases that
  // sweep num_switches and max_ip through their extremes.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph_switches [7] = '{8, 8, 3, 0, 15, 1, 8};
    int ph_src_lim  [7] = '{1000, 65535, 0, 500, 40000, 65535, 1000};
    int ph_beats    [7] = '{250, 200, 150, 80, 200, 100, 220};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset config (8 switches, max source 1000).
    queue_query(1, 0, 150);                 // nothing opened yet: drop
    queue_open(0, 3, 4, 5, 6);              // id zero: ack, no write
    queue_open(9, 1, 1, 0, 10);             // id past the table: error
    queue_open(1, 0, 2, 100, 199);
    queue_open(2, 1, 3, 200, 299);
    queue_open(3, 2, 0, 300, 250);          // owns nothing
    queue_open(4, 9, 0, 0, 10);             // left id out of range
    queue_open(4, 0, 15, 0, 10);            // right id out of range
    queue_query(1, 0, 150);                 // deliver
    queue_query(1, 0, 250);                 // forward right
    queue_query(2, 0, 150);                 // forward left
    queue_query(2, 0, 300);                 // right neighbor has empty range: drop
    queue_query(1, 1001, 150);              // source just over max: drop
    queue_query(1, 1000, 100);              // source at max, low edge: deliver
    queue_query(0, 0, 0);                   // no switch: drop
    queue_query(12, 0, 65535);              // id above table: drop
    queue_query(3, 0, 275);                 // forward left from an empty-range switch
    queue_open(8, 7, 0, 0, 65535);          // left neighbor not opened
    queue_query(8, 0, 65535);               // deliver at top address
    queue_open(7, 8, 8, 0, 0);
    queue_query(7, 999, 5);                 // forward left with full range
    queue_query(2, 0, 199);                 // forward left at high edge
    queue_open(1, 0, 0, 0, 0);              // overwrite entry 1
    queue_query(2, 0, 150);                 // old range gone: drop
    wait_until_drained(4);

    for (int p = 0; p < 7; p++) begin
      set_rules_config(ph_switches[p], ph_src_lim[p]);
      steady_flow = (p == 1);
      for (int i = 0; i < ph_beats[p]; i++)
        pending_requests.push_back(draw_switch_request());
      wait_until_drained((p == 6) ? SETTLE_CYCLES : 4);
    end

    error_count += expected_answers.size();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one request beat at a time, held while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Beat taken at this edge: predict now, in acceptance order.
      if (in_valid && !in_stall)
        expected_answers.push_back(predict_flow_answer(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && (steady_flow || $urandom_range(99) >= 30)) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each answer beat and drives out_stall.
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  int hold_left = 0;
  bit pressure_done = 1'b0;

  always @(posedge clk) begin : check_answers
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("answer beat with nothing outstanding: %h", out_data);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          compare_field("result_kind", want.result_kind, out_data.result_kind);
          compare_field("action", want.action, out_data.action);
          compare_field("out_port", want.out_port, out_data.out_port);
          compare_field("match_low", want.match_low, out_data.match_low);
          compare_field("match_high", want.match_high, out_data.match_high);
        end
        answers_seen++;
      end
      // One long hold-off early in the first random phase; the driver keeps
      // offering, so the block's output and input both back up.
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!pressure_done && answers_seen >= 60) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= !steady_flow && ($urandom_range(99) < 30);
      end
    end
  end

  // Watchdog: counts cycles with work outstanding but no beat moving.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_requests.size() == 0 && !in_valid && expected_answers.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

>>> filelist.f
design/snfr_pkg.sv
design/snfr_table.sv
design/snfr_ctrl.sv
design/switch_neighbor_flow_rule.sv
tb/tb_switch_neighbor_flow_rule.sv
